@@ sv/shm_pkg.sv @@
// Package: shared constants, codes, types and fixed-point helpers of the spin Hamiltonian block.
package shm_pkg;

  localparam int MAX_SITES_DEF  = 24;
  localparam int MAX_BONDS_DEF  = 64;
  localparam int MAX_STATES_DEF = 4096;
  localparam int HALF_DEPTH_DEF = 4096;

  // Width of a count that can reach the number of states of the largest build.
  localparam int IDX_W = 17;

  typedef enum logic [2:0] {
    OP_LOAD_BOND  = 3'd0,
    OP_LOAD_STATE = 3'd1,
    OP_LOAD_TABLE = 3'd2,
    OP_RUN        = 3'd3,
    OP_READ       = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_SITES  = 2'd0,
    CFG_BONDS  = 2'd1,
    CFG_STATES = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_BOND, S_BW, S_W, S_ST, S_V, S_WV, S_WVV, S_PV, S_T, S_TV,
    S_NEXT, S_RESP
  } state_t;

  typedef struct packed {
    logic              ovf;
    logic signed [31:0] val;
  } sat32_t;

  typedef struct packed {
    logic              ovf;
    logic signed [47:0] val;
  } sat48_t;

  localparam logic signed [39:0] Q32_HI = 40'sd2147483647;
  localparam logic signed [39:0] Q32_LO = -40'sd2147483648;
  localparam logic signed [49:0] Q48_HI = 50'sd140737488355327;
  localparam logic signed [49:0] Q48_LO = -50'sd140737488355328;

  // Product shifted right by 24 or 25 with rounding to nearest, ties upward.
  function automatic logic signed [39:0] round_q(input logic signed [63:0] p,
                                                 input logic sh25);
    logic signed [63:0] s;
    s = p + (sh25 ? 64'sd16777216 : 64'sd8388608);
    return sh25 ? 40'(s >>> 25) : 40'(s >>> 24);
  endfunction

  // Clamp to the Q7.24 range and flag an overflow.
  function automatic sat32_t sat32(input logic signed [39:0] x);
    sat32_t r;
    r.ovf = 1'b0;
    if (x > Q32_HI) begin
      r.ovf = 1'b1;
      r.val = 32'sh7FFFFFFF;
    end else if (x < Q32_LO) begin
      r.ovf = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.val = 32'(x);
    end
    return r;
  endfunction

  function automatic sat32_t add32(input logic signed [31:0] a, input logic signed [39:0] b);
    return sat32(40'(a) + b);
  endfunction

  // Saturating addition to the Q23.24 expectation sum.
  function automatic sat48_t add48(input logic signed [47:0] s, input logic signed [39:0] x);
    sat48_t r;
    logic signed [49:0] t;
    t = 50'(s) + 50'(x);
    r.ovf = 1'b0;
    if (t > Q48_HI) begin
      r.ovf = 1'b1;
      r.val = 48'sh7FFFFFFFFFFF;
    end else if (t < Q48_LO) begin
      r.ovf = 1'b1;
      r.val = 48'sh800000000000;
    end else begin
      r.val = 48'(t);
    end
    return r;
  endfunction

endpackage

@@ sv/shm_if.sv @@
// Interfaces: request channel and result channel with valid/ready handshake.
interface shm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [11:0]        entry_index;
  logic               table_select;
  logic [4:0]         first_site;
  logic [4:0]         second_site;
  logic signed [31:0] bond_weight;
  logic signed [31:0] aniso_ratio;
  logic [23:0]        spin_pattern;
  logic signed [31:0] vector_in;
  logic signed [31:0] accum_in;
  logic [11:0]        table_value;

  modport source (output valid, opcode, entry_index, table_select, first_site, second_site,
                  bond_weight, aniso_ratio, spin_pattern, vector_in, accum_in, table_value,
                  input ready);
  modport sink (input valid, opcode, entry_index, table_select, first_site, second_site,
                bond_weight, aniso_ratio, spin_pattern, vector_in, accum_in, table_value,
                output ready);
endinterface

interface shm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accum_out;
  logic signed [47:0] expect_product;
  logic [1:0]         status;

  modport source (output valid, accum_out, expect_product, status, input ready);
  modport sink (input valid, accum_out, expect_product, status, output ready);
endinterface

@@ sv/shm_ram.sv @@
// Single-port-write, registered-read memory.
module shm_ram #(
  parameter int W     = 32,
  parameter int AW    = 12,
  parameter int DEPTH = 4096
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/shm_mul.sv @@
// Shared signed 32 by 32 multiplier with a registered product.
module shm_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  // The product is registered before any rounding or accumulation.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ sv/spin_hamiltonian_vector_multiply.sv @@
// Top level: spin Hamiltonian times vector, memories plus a sequencer around one multiplier.
// Load requests and unknown opcodes have their result registered the next cycle.
// A read request goes through the registered accumulator memory read, then the READ and RESP states.
// A run steps through BOND, BW, W per bond, then ST, V, WV, WVV, NEXT per state, plus PV, T, TV
// for each state with antiparallel bond spins, as the shared multiplier dictates. One request at a time.
// Synchronous active-low reset clears the sequencer, output valid and registers to 2, 1, 1.
module spin_hamiltonian_vector_multiply
  import shm_pkg::*;
#(
  parameter int MAX_SITES        = MAX_SITES_DEF,
  parameter int MAX_BONDS        = MAX_BONDS_DEF,
  parameter int MAX_STATES       = MAX_STATES_DEF,
  parameter int HALF_TABLE_DEPTH = HALF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  shm_in_if.sink      in_ch,
  shm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int BAW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
  localparam int BCW = $clog2(MAX_BONDS + 1);
  localparam int SAW = $clog2(MAX_STATES);
  localparam int SCW = $clog2(MAX_STATES + 1);
  localparam int TAW = $clog2(HALF_TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic [4:0]  site_r;
  logic [6:0]  bond_r;
  logic [12:0] scount_r;

  logic [BCW-1:0] nb, k_r;
  logic [SCW-1:0] ns, j_r;
  logic [4:0]     n_sites, half;
  logic [23:0]    right_m, left_m;

  logic               accept, slot_free, run_r, sat_r, beyond_r, rd_ok_r;
  logic [IDX_W-1:0]   idx_x;
  opcode_t            op;

  logic [32:0]        mask_r;
  logic signed [31:0] bw_r, w_r, v_r, acc_r, wv_r, res_acc_r;
  logic signed [47:0] sum_r;
  logic               diag_r, ia_ok_r, ib_ok_r, partner_ok_r;

  logic [73:0]        bond_rd;
  logic [23:0]        pat_rd;
  logic [31:0]        vec_rd, acc_rd;
  logic [11:0]        low_rd, high_rd;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [39:0] rq;
  sat32_t             s32, acc_new;
  sat48_t             sum_new;

  logic [32:0]        bits_w, flip_w;
  logic [23:0]        ia_w, ib_w;
  logic [IDX_W-1:0]   partner_w;

  logic               acc_we;
  logic [SAW-1:0]     acc_raddr, vec_raddr, st_waddr;

  logic               out_valid_r;
  logic signed [31:0] out_acc_r;
  logic signed [47:0] out_exp_r;
  logic [1:0]         out_stat_r;

  assign op     = opcode_t'(in_ch.opcode);
  assign idx_x  = IDX_W'(in_ch.entry_index);
  assign accept = in_ch.valid && in_ch.ready;

  // Active counts and the split of the pattern into two table halves.
  assign nb      = (bond_r < MAX_BONDS) ? BCW'(bond_r) : BCW'(MAX_BONDS);
  assign ns      = (scount_r < MAX_STATES) ? SCW'(scount_r) : SCW'(MAX_STATES);
  assign n_sites = (site_r < MAX_SITES) ? site_r : 5'(MAX_SITES);
  assign half    = 5'((6'(n_sites) + 6'd1) >> 1);
  assign right_m = (24'd1 << half) - 24'd1;
  assign left_m  = 24'((25'd1 << n_sites) - 25'd1) ^ right_m;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_r   <= 5'd2;
      bond_r   <= 7'd1;
      scount_r <= 13'd1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SITES:  site_r   <= cfg_data[4:0];
        CFG_BONDS:  bond_r   <= cfg_data[6:0];
        CFG_STATES: scount_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memories.
  shm_ram #(.W(74), .AW(BAW), .DEPTH(MAX_BONDS)) u_bond_ram (
    .clk(clk),
    .we(accept && op == OP_LOAD_BOND && idx_x < MAX_BONDS),
    .waddr(idx_x[BAW-1:0]),
    .wdata({in_ch.aniso_ratio, in_ch.bond_weight, in_ch.second_site, in_ch.first_site}),
    .raddr(k_r[BAW-1:0]),
    .rdata(bond_rd)
  );

  assign st_waddr = (state_r == S_IDLE) ? idx_x[SAW-1:0] : j_r[SAW-1:0];

  shm_ram #(.W(24), .AW(SAW), .DEPTH(MAX_STATES)) u_pat_ram (
    .clk(clk),
    .we(accept && op == OP_LOAD_STATE && idx_x < MAX_STATES),
    .waddr(idx_x[SAW-1:0]),
    .wdata(in_ch.spin_pattern),
    .raddr(j_r[SAW-1:0]),
    .rdata(pat_rd)
  );

  assign vec_raddr = (state_r == S_WVV) ? partner_w[SAW-1:0] : j_r[SAW-1:0];

  shm_ram #(.W(32), .AW(SAW), .DEPTH(MAX_STATES)) u_vec_ram (
    .clk(clk),
    .we(accept && op == OP_LOAD_STATE && idx_x < MAX_STATES),
    .waddr(idx_x[SAW-1:0]),
    .wdata(in_ch.vector_in),
    .raddr(vec_raddr),
    .rdata(vec_rd)
  );

  assign acc_raddr = (state_r == S_IDLE) ? idx_x[SAW-1:0] : j_r[SAW-1:0];

  shm_ram #(.W(32), .AW(SAW), .DEPTH(MAX_STATES)) u_acc_ram (
    .clk(clk),
    .we((accept && op == OP_LOAD_STATE && idx_x < MAX_STATES) || acc_we),
    .waddr(st_waddr),
    .wdata(acc_we ? acc_new.val : in_ch.accum_in),
    .raddr(acc_raddr),
    .rdata(acc_rd)
  );

  shm_ram #(.W(12), .AW(TAW), .DEPTH(HALF_TABLE_DEPTH)) u_low_ram (
    .clk(clk),
    .we(accept && op == OP_LOAD_TABLE && !in_ch.table_select && idx_x < HALF_TABLE_DEPTH),
    .waddr(idx_x[TAW-1:0]),
    .wdata(in_ch.table_value),
    .raddr(ia_w[TAW-1:0]),
    .rdata(low_rd)
  );

  shm_ram #(.W(12), .AW(TAW), .DEPTH(HALF_TABLE_DEPTH)) u_high_ram (
    .clk(clk),
    .we(accept && op == OP_LOAD_TABLE && in_ch.table_select && idx_x < HALF_TABLE_DEPTH),
    .waddr(idx_x[TAW-1:0]),
    .wdata(in_ch.table_value),
    .raddr(ib_w[TAW-1:0]),
    .rdata(high_rd)
  );

  // Shared multiplier and its rounding.
  shm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  assign rq  = round_q(prod, state_r == S_W);
  assign s32 = sat32(rq);

  // Partner lookup: flip both bond spins and split the pattern into halves.
  assign bits_w    = {9'd0, pat_rd} & mask_r;
  assign flip_w    = {9'd0, pat_rd} ^ mask_r;
  assign ia_w      = flip_w[23:0] & right_m;
  assign ib_w      = (flip_w[23:0] & left_m) >> half;
  assign partner_w = IDX_W'(ia_ok_r ? low_rd : 12'd0) + IDX_W'(ib_ok_r ? high_rd : 12'd0);

  // Operand selection, accumulator update and expectation update.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_we  = 1'b0;
    acc_new = add32(acc_r, 40'sd0);
    sum_new = add48(sum_r, 40'sd0);
    case (state_r)
      S_BW: begin
        mul_a = bond_rd[41:10];
        mul_b = bond_rd[73:42];
      end
      S_V: begin
        mul_a = w_r;
        mul_b = vec_rd;
      end
      S_WV: begin
        mul_a = s32.val;
        mul_b = v_r;
      end
      S_WVV: begin
        if (diag_r) begin
          acc_we  = 1'b1;
          acc_new = add32(acc_r, -40'(wv_r));
          sum_new = add48(sum_r, -rq);
        end else begin
          acc_new = add32(acc_r, 40'(wv_r));
          sum_new = add48(sum_r, rq);
        end
      end
      S_PV: begin
        mul_a = partner_ok_r ? vec_rd : 32'sd0;
        mul_b = bw_r;
      end
      S_T: begin
        mul_a   = s32.val;
        mul_b   = v_r;
        acc_we  = 1'b1;
        acc_new = add32(acc_r, -40'(s32.val));
      end
      S_TV: begin
        sum_new = add48(sum_r, -rq);
      end
      default: ;
    endcase
  end

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && op == OP_RUN) begin
          state_nxt = (nb == '0) ? S_RESP : S_BOND;
        end else if (accept && op == OP_READ) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_RESP;
      S_BOND:  state_nxt = S_BW;
      S_BW:    state_nxt = S_W;
      S_W:     state_nxt = (ns == '0) ? S_NEXT : S_ST;
      S_ST:    state_nxt = S_V;
      S_V:     state_nxt = S_WV;
      S_WV:    state_nxt = S_WVV;
      S_WVV:   state_nxt = diag_r ? S_NEXT : S_PV;
      S_PV:    state_nxt = S_T;
      S_T:     state_nxt = S_TV;
      S_TV:    state_nxt = S_NEXT;
      S_NEXT: begin
        if (ns != '0 && j_r + SCW'(1) < ns) begin
          state_nxt = S_ST;
        end else if (k_r + BCW'(1) < nb) begin
          state_nxt = S_BOND;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP:  state_nxt = slot_free ? S_IDLE : S_RESP;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Run flags and loop counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      sat_r    <= 1'b0;
      beyond_r <= 1'b0;
      k_r      <= '0;
      j_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            run_r    <= (op == OP_RUN);
            sat_r    <= 1'b0;
            beyond_r <= 1'b0;
            k_r      <= '0;
            j_r      <= '0;
          end
        end
        S_W:  sat_r <= sat_r | s32.ovf;
        S_WV: sat_r <= sat_r | s32.ovf;
        S_WVV: begin
          sat_r <= sat_r | acc_new.ovf | sum_new.ovf;
          if (!diag_r && partner_w >= IDX_W'(ns)) begin
            beyond_r <= 1'b1;
          end
        end
        S_T:  sat_r <= sat_r | s32.ovf | acc_new.ovf;
        S_TV: sat_r <= sat_r | sum_new.ovf;
        S_NEXT: begin
          if (ns != '0 && j_r + SCW'(1) < ns) begin
            j_r <= j_r + SCW'(1);
          end else begin
            j_r <= '0;
            k_r <= k_r + BCW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        sum_r   <= '0;
        rd_ok_r <= idx_x < IDX_W'(ns);
      end
      S_READ: res_acc_r <= rd_ok_r ? acc_rd : 32'sd0;
      S_BW: begin
        bw_r   <= bond_rd[41:10];
        mask_r <= (33'd1 << bond_rd[4:0]) + (33'd1 << bond_rd[9:5]);
      end
      S_W: w_r <= s32.val;
      S_V: begin
        v_r   <= vec_rd;
        acc_r <= acc_rd;
      end
      S_WV: begin
        wv_r    <= s32.val;
        diag_r  <= (bits_w == '0) || (bits_w == mask_r);
        ia_ok_r <= ia_w < HALF_TABLE_DEPTH;
        ib_ok_r <= ib_w < HALF_TABLE_DEPTH;
      end
      S_WVV: begin
        acc_r        <= acc_new.val;
        sum_r        <= sum_new.val;
        partner_ok_r <= partner_w < IDX_W'(ns);
      end
      S_TV: sum_r <= sum_new.val;
      default: ;
    endcase
  end

  // Output register: immediate results for loads and unknown opcodes, later results for run and read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && op != OP_RUN && op != OP_READ) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_RESP && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op != OP_RUN && op != OP_READ) begin
      out_acc_r  <= '0;
      out_exp_r  <= '0;
      out_stat_r <= STAT_OK;
      case (op)
        OP_LOAD_BOND:  if (idx_x >= MAX_BONDS) out_stat_r <= STAT_RANGE;
        OP_LOAD_STATE: if (idx_x >= MAX_STATES) out_stat_r <= STAT_RANGE;
        OP_LOAD_TABLE: if (idx_x >= HALF_TABLE_DEPTH) out_stat_r <= STAT_RANGE;
        default: ;
      endcase
    end else if (state_r == S_RESP && slot_free) begin
      if (run_r) begin
        out_acc_r  <= '0;
        out_exp_r  <= sum_r;
        out_stat_r <= sat_r ? STAT_SAT : (beyond_r ? STAT_RANGE : STAT_OK);
      end else begin
        out_acc_r  <= res_acc_r;
        out_exp_r  <= '0;
        out_stat_r <= rd_ok_r ? STAT_OK : STAT_RANGE;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accum_out      = out_acc_r;
  assign out_ch.expect_product = out_exp_r;
  assign out_ch.status         = out_stat_r;

endmodule

@@ sv/shm_checker.sv @@
// Checker: port-level properties of the spin Hamiltonian block, bound to the top level.
module shm_checker
  import shm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_accum,
  input logic [47:0] out_expect,
  input logic [1:0]  out_status
);

  // A result not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // No new request is taken while a stalled result blocks the output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while output register is full");

  // Load requests and unknown opcodes answer in the next cycle.
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode != OP_RUN && in_opcode != OP_READ |=> out_valid)
    else $error("load request gave no result in the next cycle");

  // A result carries an accumulator or an expectation sum, never both, and an accumulator result is never saturated.
  a_one_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accum != '0 |-> out_expect == '0 && out_status != STAT_SAT)
    else $error("accumulator and expectation sum both set");

endmodule

bind spin_hamiltonian_vector_multiply shm_checker u_shm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .in_opcode(in_ch.opcode),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_accum(out_ch.accum_out),
  .out_expect(out_ch.expect_product),
  .out_status(out_ch.status)
);

@@ tb/sv/spin_hamiltonian_vector_multiply_tb.sv @@
// Testbench for the spin Hamiltonian vector multiply block, checked against its own predictor.
module spin_hamiltonian_vector_multiply_tb;
  import shm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes that the block does not decode.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam int TAB_SPAN = 16;  // table and state slots kept loaded for runs

  typedef struct {
    logic [2:0]  op;
    logic [11:0] idx;
    logic        sel;
    logic [4:0]  s1;
    logic [4:0]  s2;
    int          bw;
    int          ar;
    logic [23:0] pat;
    int          vin;
    int          ain;
    logic [11:0] tval;
    bit          typed;
    int          t_acc;
    longint      t_sum;
    status_t     t_st;
  } request_t;

  typedef struct {
    int      acc;
    longint  sum;
    status_t st;
  } result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  shm_in_if req_ch();
  shm_out_if res_ch();

  spin_hamiltonian_vector_multiply dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch), .out_ch(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: registers and memories as the block should hold them.
  int unsigned n_sites, n_bonds, n_states;
  logic [9:0]  bond_pair [64];
  int          bond_w [64];
  int          bond_r [64];
  logic [23:0] st_pat [4096];
  int          st_vec [4096];
  int          st_acc [4096];
  bit          st_loaded [4096];
  logic [11:0] lo_tab [4096];
  logic [11:0] hi_tab [4096];
  bit          sat_hit;

  result_t pending_results[$];
  request_t directed[$];
  int errors;
  int accepted;
  int results_seen;
  int runs_done;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x > hi) begin
      sat_hit = 1'b1;
      return hi;
    end
    if (x < lo) begin
      sat_hit = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint c32(longint x);
    return clamp(x, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint c48(longint x);
    return clamp(x, -64'sd140737488355328, 64'sd140737488355327);
  endfunction

  // Walk every active bond over every active state, updating accumulators.
  function automatic longint hamiltonian_multiply(output bit beyond);
    int unsigned nb, ns, n, half, k, j;
    longint right, left, mask, bw, w, v, wv, wvv, pv, t, sum;
    longint pat, bits, flip, ia, ib, partner;
    nb = n_bonds < 64 ? n_bonds : 64;
    ns = n_states < 4096 ? n_states : 4096;
    n = n_sites < 24 ? n_sites : 24;
    half = (n + 1) / 2;
    right = (64'sd1 <<< half) - 1;
    left = ((64'sd1 <<< n) - 1) ^ right;
    sum = 0;
    beyond = 1'b0;
    for (k = 0; k < nb; k++) begin
      mask = (64'sd1 <<< bond_pair[k][4:0]) + (64'sd1 <<< bond_pair[k][9:5]);
      bw = bond_w[k];
      w = c32(rnd_shift(bw * longint'(bond_r[k]), 25));
      for (j = 0; j < ns; j++) begin
        pat = st_pat[j];
        bits = pat & mask;
        v = st_vec[j];
        wv = c32(rnd_shift(w * v, 24));
        wvv = rnd_shift(wv * v, 24);
        if (bits == 0 || bits == mask) begin
          st_acc[j] = int'(c32(longint'(st_acc[j]) - wv));
          sum = c48(sum - wvv);
        end else begin
          flip = pat ^ mask;
          ia = flip & right;
          ib = (flip & left) >> half;
          partner = 0;
          if (ia < 4096) partner += lo_tab[ia];
          if (ib < 4096) partner += hi_tab[ib];
          pv = 0;
          if (partner < ns) pv = st_vec[partner];
          else beyond = 1'b1;
          st_acc[j] = int'(c32(longint'(st_acc[j]) + wv));
          t = c32(rnd_shift(pv * bw, 24));
          st_acc[j] = int'(c32(longint'(st_acc[j]) - t));
          sum = c48(sum + wvv);
          sum = c48(sum - rnd_shift(t * v, 24));
        end
      end
    end
    return sum;
  endfunction

  // Apply one request to the predictor and return the result it should give.
  function automatic result_t hamiltonian_step(request_t r);
    result_t e;
    bit beyond;
    int unsigned ns;
    e.acc = 0;
    e.sum = 0;
    e.st = STAT_OK;
    case (r.op)
      OP_LOAD_BOND: begin
        if (r.idx < 64) begin
          bond_pair[r.idx] = {r.s2, r.s1};
          bond_w[r.idx] = r.bw;
          bond_r[r.idx] = r.ar;
        end else e.st = STAT_RANGE;
      end
      OP_LOAD_STATE: begin
        st_pat[r.idx] = r.pat;
        st_vec[r.idx] = r.vin;
        st_acc[r.idx] = r.ain;
        st_loaded[r.idx] = 1'b1;
      end
      OP_LOAD_TABLE: begin
        if (r.sel) hi_tab[r.idx] = r.tval;
        else lo_tab[r.idx] = r.tval;
      end
      OP_RUN: begin
        sat_hit = 1'b0;
        e.sum = hamiltonian_multiply(beyond);
        e.st = sat_hit ? STAT_SAT : (beyond ? STAT_RANGE : STAT_OK);
      end
      OP_READ: begin
        ns = n_states < 4096 ? n_states : 4096;
        if (r.idx < ns) e.acc = st_acc[r.idx];
        else e.st = STAT_RANGE;
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic int rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      default: return int'($urandom_range(0, 1 << 26)) - (1 << 25);
    endcase
  endfunction

  function automatic request_t blank();
    request_t r;
    r.op = OP_READ;
    r.idx = '0;
    r.sel = 1'b0;
    r.s1 = 5'($urandom);
    r.s2 = 5'($urandom);
    r.bw = $urandom;
    r.ar = $urandom;
    r.pat = 24'($urandom);
    r.vin = $urandom;
    r.ain = $urandom;
    r.tval = 12'($urandom);
    r.typed = 1'b0;
    r.t_acc = 0;
    r.t_sum = 0;
    r.t_st = STAT_OK;
    return r;
  endfunction

  function automatic request_t mk_bond(int idx, int s1, int s2, int bw, int ar);
    request_t r = blank();
    r.op = OP_LOAD_BOND;
    r.idx = 12'(idx);
    r.s1 = 5'(s1);
    r.s2 = 5'(s2);
    r.bw = bw;
    r.ar = ar;
    return r;
  endfunction

  function automatic request_t mk_state(int idx, int pat, int vin, int ain);
    request_t r = blank();
    r.op = OP_LOAD_STATE;
    r.idx = 12'(idx);
    r.pat = 24'(pat);
    r.vin = vin;
    r.ain = ain;
    return r;
  endfunction

  function automatic request_t mk_tab(int idx, bit sel, int val);
    request_t r = blank();
    r.op = OP_LOAD_TABLE;
    r.idx = 12'(idx);
    r.sel = sel;
    r.tval = 12'(val);
    return r;
  endfunction

  function automatic request_t mk_op(logic [2:0] op, int idx);
    request_t r = blank();
    r.op = op;
    r.idx = 12'(idx);
    return r;
  endfunction

  function automatic request_t fixed(request_t r, int acc, longint sum, status_t st);
    r.typed = 1'b1;
    r.t_acc = acc;
    r.t_sum = sum;
    r.t_st = st;
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(request_t r);
    directed.insert(directed.size(), r);
  endfunction

  // Offer one request, holding it until the block takes it.
  task automatic send(request_t r);
    result_t e;
    while (!calm && $urandom_range(0, 99) < 13) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= r.op;
    req_ch.entry_index <= r.idx;
    req_ch.table_select <= r.sel;
    req_ch.first_site <= r.s1;
    req_ch.second_site <= r.s2;
    req_ch.bond_weight <= r.bw;
    req_ch.aniso_ratio <= r.ar;
    req_ch.spin_pattern <= r.pat;
    req_ch.vector_in <= r.vin;
    req_ch.accum_in <= r.ain;
    req_ch.table_value <= r.tval;
    do @(posedge clk); while (!req_ch.ready);
    e = hamiltonian_step(r);
    if (r.typed) begin
      e.acc = r.t_acc;
      e.sum = r.t_sum;
      e.st = r.t_st;
    end
    if (r.op == OP_RUN) runs_done++;
    pending_results.insert(pending_results.size(), e);
    accepted++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write, only issued once the block is idle.
  task automatic write_reg(cfg_reg_t which, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= 13'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      CFG_SITES: n_sites = val & 32'h1F;
      CFG_BONDS: n_bonds = val & 32'h7F;
      default: n_states = val & 32'h1FFF;
    endcase
  endtask

  // Random request; runs, and bonds with two different sites, only in a phase where runs are allowed.
  function automatic request_t rand_request(bit runs_ok);
    request_t r = blank();
    int unsigned p;
    int unsigned ns;
    p = $urandom_range(0, 99);
    ns = n_states < 4096 ? n_states : 4096;
    if (p < 15) begin
      r = mk_bond($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 63),
                  $urandom_range(0, 31), $urandom_range(0, 31), rand_q(), rand_q());
      if (!runs_ok && r.idx < 64) r.s2 = r.s1;
    end else if (p < 35) begin
      r = mk_state($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                             : $urandom_range(0, TAB_SPAN - 1),
                   $urandom, rand_q(), rand_q());
    end else if (p < 55) begin
      r = mk_tab($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                           : $urandom_range(0, TAB_SPAN - 1),
                 1'($urandom_range(0, 1)),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 9));
    end else if (p < 68 && runs_ok) begin
      r = mk_op(OP_RUN, $urandom);
    end else if (p < 97) begin
      r = mk_op(OP_READ, $urandom_range(0, 1) ? $urandom_range(0, TAB_SPAN - 1)
                                               : $urandom_range(0, 4095));
      if (r.idx < ns && !st_loaded[r.idx]) r.idx = 12'(r.idx % TAB_SPAN);
    end else begin
      r = mk_op(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), $urandom);
    end
    return r;
  endfunction

  // Result side: random back-pressure, in-order comparison.
  always @(posedge clk) begin
    if (!rst_n) res_ch.ready <= 1'b0;
    else res_ch.ready <= calm || $urandom_range(0, 99) >= 13;
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: acc %0d sum %0d status %0d",
                                   res_ch.accum_out, res_ch.expect_product, res_ch.status);
      end else begin
        e = pending_results.pop_front();
        if (res_ch.accum_out !== e.acc[31:0] || res_ch.expect_product !== e.sum[47:0] ||
            res_ch.status !== e.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at result %0d: acc %0d/%0d sum %0d/%0d status %0d/%0d",
                     results_seen, res_ch.accum_out, e.acc, res_ch.expect_product,
                     $signed(e.sum[47:0]), res_ch.status, e.st);
        end
      end
    end
  end

  initial begin
    int ph, i, len, wait_cycles;
    n_sites = 2;
    n_bonds = 1;
    n_states = 1;
    errors = 0;
    accepted = 0;
    results_seen = 0;
    runs_done = 0;
    calm = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SITES;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_READ;
    req_ch.entry_index <= '0;
    req_ch.table_select <= 1'b0;
    req_ch.first_site <= '0;
    req_ch.second_site <= '0;
    req_ch.bond_weight <= '0;
    req_ch.aniso_ratio <= '0;
    req_ch.spin_pattern <= '0;
    req_ch.vector_in <= '0;
    req_ch.accum_in <= '0;
    req_ch.table_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: two sites, one bond, one state.
    add_row(mk_tab(0, 1'b0, 0));
    add_row(mk_tab(1, 1'b0, 0));
    add_row(mk_tab(0, 1'b1, 0));
    add_row(mk_tab(1, 1'b1, 0));
    // Largest weight and ratio on an antiparallel pair: saturates.
    add_row(mk_bond(0, 0, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    add_row(mk_state(0, 24'h000001, 32'sh7FFFFFFF, 32'sh80000000));
    add_row(mk_op(OP_RUN, 0));
    add_row(mk_op(OP_READ, 0));
    add_row(fixed(mk_op(OP_READ, 1), 0, 0, STAT_RANGE));
    add_row(fixed(mk_op(OP_READ, 4095), 0, 0, STAT_RANGE));
    add_row(fixed(mk_bond(64, 31, 31, 1, 1), 0, 0, STAT_RANGE));
    add_row(fixed(mk_bond(4095, 0, 0, 1, 1), 0, 0, STAT_RANGE));
    add_row(fixed(mk_state(4095, 24'hFFFFFF, 32'sh80000000, 32'sh7FFFFFFF),
                  0, 0, STAT_OK));
    add_row(fixed(mk_tab(4095, 1'b1, 12'hFFF), 0, 0, STAT_OK));
    add_row(fixed(mk_op(OP_SPARE_A, 0), 0, 0, STAT_OK));
    add_row(fixed(mk_op(OP_SPARE_B, 4095), 0, 0, STAT_OK));
    add_row(fixed(mk_op(OP_SPARE_C, 7), 0, 0, STAT_OK));
    // Equal sites, most negative weight and ratio.
    add_row(mk_bond(0, 1, 1, 32'sh80000000, 32'sh80000000));
    add_row(mk_op(OP_RUN, 0));
    // Sites above the pattern read as zero.
    add_row(mk_bond(0, 30, 31, 1 << 24, 1 << 24));
    add_row(mk_op(OP_RUN, 0));
    // Partner index beyond the state count.
    add_row(mk_bond(0, 0, 1, 1 << 24, 1 << 24));
    add_row(mk_state(0, 24'h000001, 1 << 24, 0));
    add_row(mk_tab(1, 1'b1, 5));
    add_row(mk_op(OP_RUN, 0));
    add_row(mk_op(OP_READ, 0));
    foreach (directed[k]) send(directed[k]);

    // Fill the slots that runs of up to eight sites and sixteen states touch.
    write_reg(CFG_SITES, 8);
    write_reg(CFG_BONDS, 8);
    write_reg(CFG_STATES, TAB_SPAN);
    for (i = 0; i < TAB_SPAN; i++) begin
      send(mk_tab(i, 1'b0, $urandom_range(0, 9)));
      send(mk_tab(i, 1'b1, $urandom_range(0, 9)));
      send(mk_state(i, $urandom, rand_q(), rand_q()));
    end
    for (i = 0; i < 8; i++)
      send(mk_bond(i, $urandom_range(0, 31), $urandom_range(0, 31), rand_q(), rand_q()));

    // Random phases over small lattices, one of them without any idling.
    for (ph = 0; ph < 20; ph++) begin
      write_reg(CFG_SITES, ph == 0 ? 2 : $urandom_range(2, 8));
      write_reg(CFG_BONDS, ph == 1 ? 1 : $urandom_range(1, 8));
      write_reg(CFG_STATES, ph == 2 ? TAB_SPAN : $urandom_range(1, TAB_SPAN));
      calm = (ph == 5);
      len = $urandom_range(22, 42);
      for (i = 0; i < len; i++) send(rand_request(1));
    end
    calm = 0;

    // Widest lattice and every bond slot: equal-site bonds need no table.
    write_reg(CFG_SITES, 24);
    write_reg(CFG_BONDS, 64);
    write_reg(CFG_STATES, 2);
    for (i = 0; i < 64; i++)
      send(mk_bond(i, i % 32, i % 32, rand_q(), rand_q()));
    send(mk_op(OP_RUN, 0));
    send(mk_op(OP_READ, 0));
    send(mk_op(OP_READ, 1));

    // Large state counts: loads, reads and undecoded opcodes only, no run.
    for (ph = 0; ph < 4; ph++) begin
      write_reg(CFG_STATES, ph == 0 ? 4096 : $urandom_range(17, 4095));
      for (i = 0; i < 30; i++) send(rand_request(0));
    end

    // Back to small lattices; rebuild varied bonds first.
    write_reg(CFG_SITES, $urandom_range(2, 8));
    write_reg(CFG_BONDS, 8);
    write_reg(CFG_STATES, TAB_SPAN);
    for (i = 0; i < 8; i++)
      send(mk_bond(i, $urandom_range(0, 31), $urandom_range(0, 31), rand_q(), rand_q()));
    for (ph = 0; ph < 4; ph++) begin
      write_reg(CFG_SITES, $urandom_range(2, 8));
      write_reg(CFG_BONDS, $urandom_range(1, 8));
      write_reg(CFG_STATES, $urandom_range(1, TAB_SPAN));
      for (i = 0; i < 40; i++) send(rand_request(1));
    end

    req_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    $display("Covered %0d requests, %0d of them runs, %0d results compared.",
             accepted, runs_done, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
